@@ hdl/rhcm_pkg.sv @@
// ----------------------------------------------------------------------------
// rhcm_pkg
// Shared widths, constants and types of the RGB565 to HSL color matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package rhcm_pkg;

   localparam int PIXEL_W   = 16;
   localparam int CHAN_W    = 8;
   localparam int SUM_W     = 9;
   localparam int LUMX_W    = 12;
   localparam int PROD_W    = 24;
   localparam int CSR_IDX_W = 3;

   // divider geometry; numerator and quotient widths shared by both
   localparam int DIV_NUM_W = 16;
   localparam int DIV_QUO_W = 8;
   localparam int HUE_DEN_W = 8;
   localparam int SAT_DEN_W = 9;

   localparam logic [CHAN_W-1:0] HSL_SCALE  = 8'd240;
   localparam logic [CHAN_W-1:0] HUE_SIXTH  = 8'd40;
   localparam logic [CHAN_W-1:0] HUE_GREEN  = 8'd80;
   localparam logic [CHAN_W-1:0] HUE_BLUE   = 8'd160;
   localparam logic [SUM_W-1:0]  LUM_TWICE  = 9'd480;

   // luminance is floor(8 * sum / 17), i.e. sum * 240 / 255 / 2
   localparam logic [LUMX_W-1:0] LUM_RECIP  = 12'd3855;
   localparam logic [LUMX_W-1:0] LUM_DIV    = 12'd17;

   // luminance zero and luminance at or below half scale, as sum bounds
   localparam logic [SUM_W-1:0]  SUM_LUM_ZERO_MAX = 9'd2;
   localparam logic [SUM_W-1:0]  SUM_LUM_LOW_MAX  = 9'd257;

   localparam logic [CHAN_W-1:0] RST_HUE_LOW  = 8'd130;
   localparam logic [CHAN_W-1:0] RST_HUE_HIGH = 8'd170;
   localparam logic [CHAN_W-1:0] RST_SAT_LOW  = 8'd100;
   localparam logic [CHAN_W-1:0] RST_SAT_HIGH = 8'd240;
   localparam logic [CHAN_W-1:0] RST_LUM_LOW  = 8'd20;
   localparam logic [CHAN_W-1:0] RST_LUM_HIGH = 8'd120;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HUE_LOW  = 3'd0,
      CSR_HUE_HIGH = 3'd1,
      CSR_SAT_LOW  = 3'd2,
      CSR_SAT_HIGH = 3'd3,
      CSR_LUM_LOW  = 3'd4,
      CSR_LUM_HIGH = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      HUE_SEL_RED,
      HUE_SEL_GREEN,
      HUE_SEL_BLUE
   } hue_sel_type;

   typedef struct packed {
      logic        neg;
      hue_sel_type sel;
      logic        gray;
   } hue_side_type;

   typedef struct packed {
      logic              zero;
      logic              ovf;
      logic [CHAN_W-1:0] lum;
   } sat_side_type;

endpackage

`default_nettype wire

@@ hdl/rhcm_if.sv @@
// ----------------------------------------------------------------------------
// rhcm_if
// Valid/ready channels of the color matcher: pixel request and HSL response.
// ----------------------------------------------------------------------------
`default_nettype none

interface rhcm_req_if;
   import rhcm_pkg::*;

   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] pixel_word;

   modport source (output valid, output pixel_word, input ready);
   modport sink   (input valid, input pixel_word, output ready);
endinterface

interface rhcm_rsp_if;
   import rhcm_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] hue;
   logic [CHAN_W-1:0] saturation;
   logic [CHAN_W-1:0] luminance;
   logic              is_match;

   modport source (output valid, output hue, output saturation, output luminance,
                   output is_match, input ready);
   modport sink   (input valid, input hue, input saturation, input luminance,
                   input is_match, output ready);
endinterface

`default_nettype wire

@@ hdl/rhcm_div_pipe.sv @@
// ----------------------------------------------------------------------------
// rhcm_div_pipe
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// The numerator must be below den << QUO_W.
// ----------------------------------------------------------------------------
`default_nettype none

module rhcm_div_pipe #(
   parameter int NUM_W  = 16,
   parameter int DEN_W  = 9,
   parameter int QUO_W  = 8,
   parameter int SIDE_W = 1
) (
   input  wire logic              clock,
   input  wire logic [QUO_W-1:0]  en,
   input  wire logic [NUM_W-1:0]  num,
   input  wire logic [DEN_W-1:0]  den,
   input  wire logic [SIDE_W-1:0] side_in,
   output logic      [QUO_W-1:0]  quo,
   output logic      [SIDE_W-1:0] side_out
);

   logic [DEN_W-1:0]  rem_ff  [QUO_W];
   logic [QUO_W-1:0]  qn_ff   [QUO_W];
   logic [DEN_W-1:0]  den_ff  [QUO_W];
   logic [SIDE_W-1:0] side_ff [QUO_W];

   for (genvar k = 0; k < QUO_W; k++) begin : g_stage
      logic [DEN_W-1:0]  rem_prev;
      logic [QUO_W-1:0]  qn_prev;
      logic [DEN_W-1:0]  den_prev;
      logic [SIDE_W-1:0] side_prev;
      logic [DEN_W:0]    trial;
      logic [DEN_W:0]    diff;
      logic              ge;
      logic [DEN_W-1:0]  rem_in;
      logic [QUO_W-1:0]  qn_in;

      if (k == 0) begin : g_first
         assign rem_prev  = DEN_W'(num[NUM_W-1:QUO_W]);
         assign qn_prev   = num[QUO_W-1:0];
         assign den_prev  = den;
         assign side_prev = side_in;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign qn_prev   = qn_ff[k-1];
         assign den_prev  = den_ff[k-1];
         assign side_prev = side_ff[k-1];
      end

      always_comb begin
         trial  = {rem_prev, qn_prev[QUO_W-1]};
         diff   = trial - {1'b0, den_prev};
         ge     = (trial >= {1'b0, den_prev});
         rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         qn_in  = {qn_prev[QUO_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (en[k]) begin
            rem_ff[k]  <= rem_in;
            qn_ff[k]   <= qn_in;
            den_ff[k]  <= den_prev;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign quo      = qn_ff[QUO_W-1];
   assign side_out = side_ff[QUO_W-1];

endmodule

`default_nettype wire

@@ hdl/rgb565_hsl_color_match.sv @@
// ----------------------------------------------------------------------------
// rgb565_hsl_color_match
// RGB565 pixel to HSL (0..240 scale) converter with a window match flag.
// ----------------------------------------------------------------------------
// Takes one RGB565 pixel per clock when not stalled and returns hue,
// saturation and luminance on a 0..240 scale plus a flag that is set when all
// three lie inside the inclusive windows held in six csr registers (index
// 0..5: hue low/high, saturation low/high, luminance low/high; other indexes
// are ignored). There are four stages of unpack and max/min, spread and sum,
// scaling and luminance product, and luminance correction, eight stages for
// the two restoring dividers (hue and saturation, one quotient bit per stage)
// and one output stage. Sustained rate is one pixel per clock when not stalled;
// each stage holds its item under backpressure and empty stages keep filling,
// so the request side stays ready until every stage is occupied. The user must
// write windows only while the pipeline is empty; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb565_hsl_color_match (
   input  wire logic                          clock,
   input  wire logic                          reset,
   rhcm_req_if.sink                           req_bus,
   rhcm_rsp_if.source                         rsp_bus,
   input  wire logic                          csr_wr_en,
   input  wire logic [rhcm_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [rhcm_pkg::CHAN_W-1:0]    csr_wdata
);
   import rhcm_pkg::*;

   localparam int DIV_FIRST = 4;
   localparam int NUM_STG   = DIV_FIRST + DIV_QUO_W + 1;
   localparam int OUT_STG   = NUM_STG - 1;

   // csr registers
   logic [CHAN_W-1:0] hue_low_ff, hue_high_ff, sat_low_ff, sat_high_ff;
   logic [CHAN_W-1:0] lum_low_ff, lum_high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hue_low_ff  <= RST_HUE_LOW;
         hue_high_ff <= RST_HUE_HIGH;
         sat_low_ff  <= RST_SAT_LOW;
         sat_high_ff <= RST_SAT_HIGH;
         lum_low_ff  <= RST_LUM_LOW;
         lum_high_ff <= RST_LUM_HIGH;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_HUE_LOW:  hue_low_ff  <= csr_wdata;
            CSR_HUE_HIGH: hue_high_ff <= csr_wdata;
            CSR_SAT_LOW:  sat_low_ff  <= csr_wdata;
            CSR_SAT_HIGH: sat_high_ff <= csr_wdata;
            CSR_LUM_LOW:  lum_low_ff  <= csr_wdata;
            CSR_LUM_HIGH: lum_high_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // pipeline control: a stage loads when empty or when its successor moves
   logic [NUM_STG-1:0] vld_ff, vld_in, stg_en;

   always_comb begin
      stg_en[OUT_STG] = !vld_ff[OUT_STG] || rsp_bus.ready;
      for (int i = OUT_STG - 1; i >= 0; i--) begin
         stg_en[i] = !vld_ff[i] || stg_en[i+1];
      end
      vld_in = vld_ff;
      for (int i = 0; i < NUM_STG; i++) begin
         if (stg_en[i]) begin
            vld_in[i] = (i == 0) ? req_bus.valid : vld_ff[(i == 0) ? 0 : i - 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_bus.ready = stg_en[0];

   // stage 1: unpack, max, min, dominant channel
   logic [CHAN_W-1:0] r_in, g_in, b_in, mx_a, mn_a, mx_in, mn_in;
   hue_sel_type       sel_in;
   logic [CHAN_W-1:0] s1_r_ff, s1_g_ff, s1_b_ff, s1_mx_ff, s1_mn_ff;
   hue_sel_type       s1_sel_ff;

   always_comb begin
      r_in  = {req_bus.pixel_word[15:11], 3'b000};
      g_in  = {req_bus.pixel_word[10:5], 2'b00};
      b_in  = {req_bus.pixel_word[4:0], 3'b000};
      mx_a  = (g_in > r_in) ? g_in : r_in;
      mx_in = (b_in > mx_a) ? b_in : mx_a;
      mn_a  = (g_in < r_in) ? g_in : r_in;
      mn_in = (b_in < mn_a) ? b_in : mn_a;
      priority if (mx_in == r_in) begin
         sel_in = HUE_SEL_RED;
      end else if (mx_in == g_in) begin
         sel_in = HUE_SEL_GREEN;
      end else begin
         sel_in = HUE_SEL_BLUE;
      end
   end

   always_ff @(posedge clock) begin
      if (stg_en[0]) begin
         s1_r_ff   <= r_in;
         s1_g_ff   <= g_in;
         s1_b_ff   <= b_in;
         s1_mx_ff  <= mx_in;
         s1_mn_ff  <= mn_in;
         s1_sel_ff <= sel_in;
      end
   end

   // stage 2: spread, sum, hue difference magnitude and sign
   logic [CHAN_W-1:0] hd_a, hd_b, dif_in, hmag_in;
   logic [CHAN_W:0]   hd_diff, hd_negd;
   logic [SUM_W-1:0]  sum_in;
   hue_side_type      hside_in;
   logic [CHAN_W-1:0] s2_dif_ff, s2_hmag_ff;
   logic [SUM_W-1:0]  s2_sum_ff;
   hue_side_type      s2_hside_ff;

   always_comb begin
      unique case (s1_sel_ff)
         HUE_SEL_RED: begin
            hd_a = s1_g_ff;
            hd_b = s1_b_ff;
         end
         HUE_SEL_GREEN: begin
            hd_a = s1_b_ff;
            hd_b = s1_r_ff;
         end
         HUE_SEL_BLUE: begin
            hd_a = s1_r_ff;
            hd_b = s1_g_ff;
         end
         default: begin
            hd_a = s1_r_ff;
            hd_b = s1_g_ff;
         end
      endcase
      hd_diff       = {1'b0, hd_a} - {1'b0, hd_b};
      hd_negd       = ~hd_diff + 1'b1;
      hmag_in       = hd_diff[CHAN_W] ? hd_negd[CHAN_W-1:0] : hd_diff[CHAN_W-1:0];
      dif_in        = s1_mx_ff - s1_mn_ff;
      sum_in        = {1'b0, s1_mx_ff} + {1'b0, s1_mn_ff};
      hside_in.neg  = hd_diff[CHAN_W];
      hside_in.sel  = s1_sel_ff;
      hside_in.gray = (s1_mx_ff == s1_mn_ff);
   end

   always_ff @(posedge clock) begin
      if (stg_en[1]) begin
         s2_dif_ff   <= dif_in;
         s2_sum_ff   <= sum_in;
         s2_hmag_ff  <= hmag_in;
         s2_hside_ff <= hside_in;
      end
   end

   // stage 3: scaled numerators, saturation denominator, luminance product
   logic [DIV_NUM_W-1:0] hnum_in, snum_in;
   logic [LUMX_W-1:0]    lumx_in;
   logic [PROD_W-1:0]    prod_in;
   logic [SAT_DEN_W-1:0] sden_in;
   logic                 szero_in;
   logic [DIV_NUM_W-1:0] s3_hnum_ff, s3_snum_ff;
   logic [LUMX_W-1:0]    s3_lumx_ff;
   logic [PROD_W-1:0]    s3_prod_ff;
   logic [SAT_DEN_W-1:0] s3_sden_ff;
   logic                 s3_szero_ff;
   logic [CHAN_W-1:0]    s3_dif_ff;
   hue_side_type         s3_hside_ff;

   always_comb begin
      hnum_in  = (DIV_NUM_W'(s2_hmag_ff) << 5) + (DIV_NUM_W'(s2_hmag_ff) << 3);
      snum_in  = (DIV_NUM_W'(s2_dif_ff) << 8) - (DIV_NUM_W'(s2_dif_ff) << 4);
      lumx_in  = {s2_sum_ff, 3'b000};
      prod_in  = PROD_W'(lumx_in) * PROD_W'(LUM_RECIP);
      sden_in  = (s2_sum_ff <= SUM_LUM_LOW_MAX) ? s2_sum_ff : LUM_TWICE - s2_sum_ff;
      szero_in = s2_hside_ff.gray || (s2_sum_ff <= SUM_LUM_ZERO_MAX) ||
                 (s2_sum_ff >= LUM_TWICE);
   end

   always_ff @(posedge clock) begin
      if (stg_en[2]) begin
         s3_hnum_ff  <= hnum_in;
         s3_snum_ff  <= snum_in;
         s3_lumx_ff  <= lumx_in;
         s3_prod_ff  <= prod_in;
         s3_sden_ff  <= sden_in;
         s3_szero_ff <= szero_in;
         s3_dif_ff   <= s2_dif_ff;
         s3_hside_ff <= s2_hside_ff;
      end
   end

   // stage 4: luminance correction, saturation overflow check
   logic [CHAN_W-1:0]    lq0;
   logic [LUMX_W-1:0]    lrem;
   sat_side_type         sside_in;
   logic [DIV_NUM_W-1:0] s4_hnum_ff, s4_snum_ff;
   logic [SAT_DEN_W-1:0] s4_sden_ff;
   logic [CHAN_W-1:0]    s4_dif_ff;
   hue_side_type         s4_hside_ff;
   sat_side_type         s4_sside_ff;

   always_comb begin
      lq0           = s3_prod_ff[PROD_W-1 -: CHAN_W];
      lrem          = s3_lumx_ff - (LUMX_W'(lq0) << 4) - LUMX_W'(lq0);
      sside_in.lum  = (lrem >= LUM_DIV) ? lq0 + 1'b1 : lq0;
      sside_in.zero = s3_szero_ff;
      sside_in.ovf  = ({1'b0, s3_snum_ff} >= {s3_sden_ff, 8'h00});
   end

   always_ff @(posedge clock) begin
      if (stg_en[3]) begin
         s4_hnum_ff  <= s3_hnum_ff;
         s4_snum_ff  <= s3_snum_ff;
         s4_sden_ff  <= s3_sden_ff;
         s4_dif_ff   <= s3_dif_ff;
         s4_hside_ff <= s3_hside_ff;
         s4_sside_ff <= sside_in;
      end
   end

   // dividers
   logic [DIV_QUO_W-1:0] hue_quo, sat_quo;
   hue_side_type         hue_side;
   sat_side_type         sat_side;

   rhcm_div_pipe #(
      .NUM_W  (DIV_NUM_W),
      .DEN_W  (HUE_DEN_W),
      .QUO_W  (DIV_QUO_W),
      .SIDE_W ($bits(hue_side_type))
   ) u_hue_div (
      .clock    (clock),
      .en       (stg_en[DIV_FIRST +: DIV_QUO_W]),
      .num      (s4_hnum_ff),
      .den      (s4_dif_ff),
      .side_in  (s4_hside_ff),
      .quo      (hue_quo),
      .side_out (hue_side)
   );

   rhcm_div_pipe #(
      .NUM_W  (DIV_NUM_W),
      .DEN_W  (SAT_DEN_W),
      .QUO_W  (DIV_QUO_W),
      .SIDE_W ($bits(sat_side_type))
   ) u_sat_div (
      .clock    (clock),
      .en       (stg_en[DIV_FIRST +: DIV_QUO_W]),
      .num      (s4_snum_ff),
      .den      (s4_sden_ff),
      .side_in  (s4_sside_ff),
      .quo      (sat_quo),
      .side_out (sat_side)
   );

   // output stage: hue sector offset, saturation clamp, window match
   logic [CHAN_W-1:0] hue_in, sat_in;
   logic              match_in;
   logic [CHAN_W-1:0] hue_ff, sat_ff, lum_ff;
   logic              match_ff;

   always_comb begin
      unique case (hue_side.sel)
         HUE_SEL_RED:   hue_in = hue_side.neg ? HSL_SCALE - hue_quo : hue_quo;
         HUE_SEL_GREEN: hue_in = hue_side.neg ? HUE_GREEN - hue_quo : HUE_GREEN + hue_quo;
         HUE_SEL_BLUE:  hue_in = hue_side.neg ? HUE_BLUE - hue_quo : HUE_BLUE + hue_quo;
         default:       hue_in = '0;
      endcase
      if (hue_side.gray) begin
         hue_in = '0;
      end
      priority if (sat_side.zero) begin
         sat_in = '0;
      end else if (sat_side.ovf || sat_quo > HSL_SCALE) begin
         sat_in = HSL_SCALE;
      end else begin
         sat_in = sat_quo;
      end
      match_in = (hue_in >= hue_low_ff) && (hue_in <= hue_high_ff) &&
                 (sat_in >= sat_low_ff) && (sat_in <= sat_high_ff) &&
                 (sat_side.lum >= lum_low_ff) && (sat_side.lum <= lum_high_ff);
   end

   always_ff @(posedge clock) begin
      if (stg_en[OUT_STG]) begin
         hue_ff   <= hue_in;
         sat_ff   <= sat_in;
         lum_ff   <= sat_side.lum;
         match_ff <= match_in;
      end
   end

   assign rsp_bus.valid      = vld_ff[OUT_STG];
   assign rsp_bus.hue        = hue_ff;
   assign rsp_bus.saturation = sat_ff;
   assign rsp_bus.luminance  = lum_ff;
   assign rsp_bus.is_match   = match_ff;

   // checks
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> vld_ff[0])
      else $error("transfer did not enter first stage");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      ((&vld_ff) && !rsp_bus.ready) |-> !req_bus.ready)
      else $error("request ready while pipeline full and stalled");

   a_div_hold: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[DIV_FIRST] && !stg_en[DIV_FIRST]) |=> vld_ff[DIV_FIRST])
      else $error("stalled divider stage lost its item");

   a_out_range: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.hue <= HSL_SCALE) && (rsp_bus.saturation <= HSL_SCALE))
      else $error("hue or saturation beyond scale");

endmodule

`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the RGB565 to HSL color matcher.
// ----------------------------------------------------------------------------
// Drives pixels over the request channel and takes responses under random
// stalls on both sides. A scoreboard converts each accepted pixel to hue,
// saturation, luminance and match flag against its own copy of the windows,
// and checks responses in order. Windows are reprogrammed between batches
// while the pipeline is empty, including open, unreachable, inverted and
// random windows.
// ----------------------------------------------------------------------------

module testbench;
   import rhcm_pkg::*;

   localparam int FULL_SCALE   = HSL_SCALE;
   localparam int CHAN_FULL    = 255;
   localparam int SIXTH        = HUE_SIXTH;
   localparam int DOUBLE_SCALE = LUM_TWICE;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   localparam logic [PIXEL_W-1:0] BRIGHT_MASK = 16'hE71C;

   localparam int NUM_SETTINGS  = 7;
   localparam int BATCH_ITEMS   = 93;
   localparam int HOLD_CYCLES   = 80;
   localparam int SETTLE_CYCLES = 20;
   localparam int IDLE_LIMIT    = 1000;

   localparam logic [PIXEL_W-1:0] DIRECTED_PIXELS [20] = '{
      16'h0000, 16'hFFFF, 16'h8410, 16'hFFDF, 16'h0821,
      16'hF800, 16'h07E0, 16'h001F, 16'hFFE0, 16'h07FF,
      16'hF81F, 16'hFFC0, 16'h07DF, 16'hF821, 16'hF801,
      16'hE7FC, 16'hFFFE, 16'h0010, 16'h0020, 16'h0001
   };

   typedef struct packed {
      logic [CHAN_W-1:0] hue;
      logic [CHAN_W-1:0] saturation;
      logic [CHAN_W-1:0] luminance;
      logic              is_match;
   } hsl_result_type;

   class hsl_scoreboard;
      hsl_result_type    expected_q[$];
      logic [CHAN_W-1:0] window [6];
      int                errors;

      function new();
         window[CSR_HUE_LOW]  = RST_HUE_LOW;
         window[CSR_HUE_HIGH] = RST_HUE_HIGH;
         window[CSR_SAT_LOW]  = RST_SAT_LOW;
         window[CSR_SAT_HIGH] = RST_SAT_HIGH;
         window[CSR_LUM_LOW]  = RST_LUM_LOW;
         window[CSR_LUM_HIGH] = RST_LUM_HIGH;
         errors = 0;
      endfunction

      // spare indexes fall outside the window set and are dropped
      function void set_window(logic [CSR_IDX_W-1:0] idx, logic [CHAN_W-1:0] value);
         if (idx <= CSR_LUM_HIGH) begin
            window[idx] = value;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function int limit_to_scale(int v);
         if (v < 0) begin
            return 0;
         end
         if (v > FULL_SCALE) begin
            return FULL_SCALE;
         end
         return v;
      endfunction

      function bit in_window(int v, logic [CHAN_W-1:0] lo, logic [CHAN_W-1:0] hi);
         return v >= int'(lo) && v <= int'(hi);
      endfunction

      function hsl_result_type pixel_to_hsl(logic [PIXEL_W-1:0] px);
         int             red, grn, blu, hi, lo, span, total, h, s, l;
         hsl_result_type res;
         red = {px[15:11], 3'b000};
         grn = {px[10:5], 2'b00};
         blu = {px[4:0], 3'b000};
         hi = red;
         if (grn > hi) hi = grn;
         if (blu > hi) hi = blu;
         lo = red;
         if (grn < lo) lo = grn;
         if (blu < lo) lo = blu;
         span  = hi - lo;
         total = hi + lo;
         l = total * FULL_SCALE / CHAN_FULL / 2;
         if (span == 0) begin
            h = 0;
            s = 0;
         end else begin
            // red wins ties, then green
            if (hi == red) begin
               h = SIXTH * (grn - blu) / span;
               if (grn < blu) h += FULL_SCALE;
            end else if (hi == grn) begin
               h = SIXTH * (blu - red) / span + 2 * SIXTH;
            end else begin
               h = SIXTH * (red - grn) / span + 4 * SIXTH;
            end
            if (l == 0) begin
               s = 0;
            end else if (l <= FULL_SCALE / 2) begin
               s = span * FULL_SCALE / total;
            end else if (DOUBLE_SCALE - total > 0) begin
               s = span * FULL_SCALE / (DOUBLE_SCALE - total);
            end else begin
               s = 0;
            end
         end
         h = limit_to_scale(h);
         s = limit_to_scale(s);
         l = limit_to_scale(l);
         res.hue        = CHAN_W'(h);
         res.saturation = CHAN_W'(s);
         res.luminance  = CHAN_W'(l);
         res.is_match   = in_window(h, window[CSR_HUE_LOW], window[CSR_HUE_HIGH]) &&
                          in_window(s, window[CSR_SAT_LOW], window[CSR_SAT_HIGH]) &&
                          in_window(l, window[CSR_LUM_LOW], window[CSR_LUM_HIGH]);
         return res;
      endfunction

      function void note_pixel(logic [PIXEL_W-1:0] px);
         expected_q.push_back(pixel_to_hsl(px));
      endfunction

      function void compare_field(string name, logic [CHAN_W-1:0] want,
                                  logic [CHAN_W-1:0] got);
         if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_result(hsl_result_type got);
         hsl_result_type want;
         if (expected_q.size() == 0) begin
            $error("response with no pixel outstanding");
            errors++;
            return;
         end
         want = expected_q.pop_front();
         compare_field("hue", want.hue, got.hue);
         compare_field("saturation", want.saturation, got.saturation);
         compare_field("luminance", want.luminance, got.luminance);
         compare_field("is_match", CHAN_W'(want.is_match), CHAN_W'(got.is_match));
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CHAN_W-1:0]    csr_wdata;

   int send_idle_pct;
   int recv_idle_pct;
   bit hold_req;

   hsl_scoreboard sb = new();

   rhcm_req_if req_bus();
   rhcm_rsp_if rsp_bus();

   rgb565_hsl_color_match u_top (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic send_pixel(input logic [PIXEL_W-1:0] px);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.pixel_word <= px;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sb.note_pixel(px);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CHAN_W-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      sb.set_window(idx, value);
   endtask

   task automatic program_windows(input logic [CHAN_W-1:0] hl, hh, sl, sh, ll, lh);
      write_csr(CSR_HUE_LOW, hl);
      write_csr(CSR_SPARE_LO, CHAN_W'($urandom));
      write_csr(CSR_HUE_HIGH, hh);
      write_csr(CSR_SAT_LOW, sl);
      write_csr(CSR_SAT_HIGH, sh);
      write_csr(CSR_SPARE_HI, CHAN_W'($urandom));
      write_csr(CSR_LUM_LOW, ll);
      write_csr(CSR_LUM_HIGH, lh);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // mostly ordered windows, now and then an inverted one
   task automatic pick_window(output logic [CHAN_W-1:0] lo, output logic [CHAN_W-1:0] hi);
      int a, b;
      a = $urandom_range(0, 200);
      b = $urandom_range(a, 255);
      if ($urandom_range(0, 3) == 0) begin
         lo = CHAN_W'(b);
         hi = CHAN_W'(a);
      end else begin
         lo = CHAN_W'(a);
         hi = CHAN_W'(b);
      end
   endtask

   function automatic logic [PIXEL_W-1:0] random_pixel();
      int         pick;
      logic [4:0] r5;
      pick = $urandom_range(0, 99);
      r5   = 5'($urandom);
      if (pick < 55) begin
         return PIXEL_W'($urandom);
      end else if (pick < 70) begin
         return {r5, r5, 1'b0, r5};
      end else if (pick < 85) begin
         return PIXEL_W'($urandom) | BRIGHT_MASK;
      end
      // near grey
      return {r5, r5, 1'($urandom), r5 ^ 5'($urandom_range(0, 1))};
   endfunction

   // response side: random stalls plus one long hold-off on request
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready) begin
         sb.check_result({rsp_bus.hue, rsp_bus.saturation, rsp_bus.luminance,
                          rsp_bus.is_match});
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      logic [CHAN_W-1:0] hl, hh, sl, sh, ll, lh;
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.pixel_word = '0;
      rsp_bus.ready      = 1'b0;
      csr_wr_en          = 1'b0;
      csr_index          = '0;
      csr_wdata          = '0;
      send_idle_pct      = 16;
      recv_idle_pct      = 63;
      hold_req           = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset windows, corner pixels
      foreach (DIRECTED_PIXELS[i]) begin
         send_pixel(DIRECTED_PIXELS[i]);
      end
      drain_results();

      for (int setting = 0; setting < NUM_SETTINGS; setting++) begin
         if (setting < 3) begin
            send_idle_pct = 16;
            recv_idle_pct = 63;
         end else if (setting < 5) begin
            send_idle_pct = 63;
            recv_idle_pct = 16;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         case (setting)
            0: program_windows(8'd0, 8'd240, 8'd0, 8'd240, 8'd0, 8'd240);
            1: program_windows(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
            2: program_windows(8'd200, 8'd50, 8'd0, 8'd255, 8'd0, 8'd240);
            default: begin
               pick_window(hl, hh);
               pick_window(sl, sh);
               pick_window(ll, lh);
               program_windows(hl, hh, sl, sh, ll, lh);
            end
         endcase
         for (int n = 0; n < BATCH_ITEMS; n++) begin
            if (setting == 5 && n == BATCH_ITEMS / 2) begin
               drain_results();
            end
            if (setting == 6 && n == 20) begin
               hold_req = 1'b1;
            end
            send_pixel(random_pixel());
         end
         drain_results();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.pending() != 0) begin
         $error("%0d responses never arrived", sb.pending());
      end
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hdl/rhcm_pkg.sv
hdl/rhcm_if.sv
hdl/rhcm_div_pipe.sv
hdl/rgb565_hsl_color_match.sv
test/testbench.sv
